// ===== rtl/core/sdpf_pkg.sv =====
// Shared types and constants for the spectrum dominant peak finder.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package sdpf_pkg;

    // Peak table and frame sizing
    localparam int NUM_PEAKS = 3;
    localparam int MAX_BINS  = 2048;
    localparam int BIN_W     = $clog2(MAX_BINS);
    localparam int BCNT_W    = $clog2(MAX_BINS + 2);
    localparam int IDX_W     = (NUM_PEAKS > 1) ? $clog2(NUM_PEAKS) : 1;
    localparam int TOTAL_W   = $clog2(NUM_PEAKS + 1);

    // Field widths
    localparam int MAG_W     = 32;
    localparam int RATIO_W   = 9;
    localparam int RATE_W    = 24;
    localparam int LOG2_W    = 4;
    localparam int FREQ_W    = 23;
    localparam int Q_SHIFT   = 8;

    // Valid FFT size range (log2)
    localparam int LOG2_MIN  = 9;
    localparam int LOG2_MAX  = 12;

    // Frame summary queue depth (power of two)
    localparam int QDEPTH    = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [RATIO_W-1:0] RATIO_RST = RATIO_W'(26);
    localparam logic [RATE_W-1:0]  RATE_RST  = RATE_W'(1000000);
    localparam logic [LOG2_W-1:0]  LOG2_RST  = LOG2_W'(10);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_RATIO   = 2'd0,
        REG_SAMPLE_RATE = 2'd1,
        REG_FFT_LOG2    = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [RATIO_W-1:0] min_ratio_q8;
        logic [RATE_W-1:0]  sample_rate_hz;
        logic [LOG2_W-1:0]  fft_size_log2;
    } cfg_t;

    typedef struct packed {
        logic [MAG_W-1:0] magnitude;
        logic             frame_end;
    } in_item_t;

    typedef struct packed {
        logic [BIN_W-1:0]   peak_bin;
        logic [FREQ_W-1:0]  peak_freq_hz;
        logic [MAG_W-1:0]   peak_amp;
        logic [TOTAL_W-1:0] peak_total;
        logic               final_res;
    } out_item_t;

    // Ranked peak table, strongest first; amplitude zero marks an empty slot
    typedef struct packed {
        logic [NUM_PEAKS-1:0][MAG_W-1:0] amp;
        logic [NUM_PEAKS-1:0][BIN_W-1:0] bin;
    } peak_tab_t;

    // One finished frame handed from front to back
    typedef struct packed {
        peak_tab_t tab;
        logic      lim_ok;
    } frame_sum_t;

endpackage

// ===== rtl/core/spectrum_dominant_peak_finder.sv =====
// Top level of the spectrum dominant peak finder: configuration registers and
// the front end / summary queue / back end chain. Depends on sdpf_pkg and sdpf_*.
`timescale 1ns / 1ps
//
//  channel | handshake         | payload                                    | beat
//  --------+-------------------+--------------------------------------------+-------------------
//  s_      | s_valid / s_ready | in_item_t  (magnitude, frame_end)          | one spectrum bin
//  m_      | m_valid / m_ready | out_item_t (peak_bin, peak_freq_hz, ...)   | one reported peak
//  cfg_    | cfg_wr_en only    | cfg_index, cfg_wdata                       | one register write
//
//  Input takes one bin per cycle while s_ready is high; the front end registers each beat.
//  A frame end produces one to three result beats through the summary queue and back end
//  stages 1 to 3 and the output register, one per cycle unless m_ready stalls; the 2-entry
//  summary queue sets how many frames may wait on the result side before s_ready drops.
//  Reset is synchronous on aresetn; no memory clearing pass is needed.
//  m_ready low stalls only the back end until the queue fills.

module spectrum_dominant_peak_finder import sdpf_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data
);

    logic [RATIO_W-1:0] ratio_reg;
    logic [RATE_W-1:0]  rate_reg;
    logic [LOG2_W-1:0]  log2_reg;
    cfg_t               cfg;

    logic       push, q_full, q_pop, q_empty;
    frame_sum_t push_data, q_data;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ratio_reg <= RATIO_RST;
            rate_reg  <= RATE_RST;
            log2_reg  <= LOG2_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MIN_RATIO:   ratio_reg <= cfg_wdata[RATIO_W-1:0];
                REG_SAMPLE_RATE: rate_reg  <= cfg_wdata[RATE_W-1:0];
                REG_FFT_LOG2:    log2_reg  <= cfg_wdata[LOG2_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.min_ratio_q8   = ratio_reg;
    assign cfg.sample_rate_hz = rate_reg;
    assign cfg.fft_size_log2  = log2_reg;

    sdpf_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fft_size_log2 (log2_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .push          (push),
        .push_data     (push_data),
        .q_full        (q_full)
    );

    sdpf_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    sdpf_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .q_empty (q_empty),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// ===== rtl/core/sdpf_front.sv =====
// Front end: accepts magnitude beats, detects local peaks, keeps the ranked table.
// Depends on sdpf_pkg; pushes one frame summary per frame into sdpf_queue.
`timescale 1ns / 1ps

module sdpf_front import sdpf_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [LOG2_W-1:0]   fft_size_log2,
    input  logic                s_valid,
    output logic                s_ready,
    input  in_item_t            s_data,
    output logic                push,
    output frame_sum_t          push_data,
    input  logic                q_full
);

    // Number of bins considered: min(N/2, MAX_BINS), zero for an unsupported size
    function automatic logic [BCNT_W-1:0] bin_limit(input logic [LOG2_W-1:0] log2n);
        int lim;
        lim = 0;
        if (int'(log2n) >= LOG2_MIN && int'(log2n) <= LOG2_MAX) begin
            lim = 1 << (int'(log2n) - 1);
            if (lim > MAX_BINS) begin
                lim = MAX_BINS;
            end
        end
        return BCNT_W'(lim);
    endfunction

    // Insert into the descending table; equal amplitudes keep the older entry
    function automatic peak_tab_t peak_insert(input peak_tab_t t, input logic [MAG_W-1:0] a,
                                              input logic [BIN_W-1:0] b, input logic en);
        peak_tab_t            r;
        logic [NUM_PEAKS-1:0] gt;
        r = t;
        for (int k = 0; k < NUM_PEAKS; k++) begin
            gt[k] = en && (a > t.amp[k]);
        end
        if (gt[0]) begin
            r.amp[0] = a;
            r.bin[0] = b;
        end
        for (int k = 1; k < NUM_PEAKS; k++) begin
            if (gt[k]) begin
                if (gt[k-1]) begin
                    r.amp[k] = t.amp[k-1];
                    r.bin[k] = t.bin[k-1];
                end else begin
                    r.amp[k] = a;
                    r.bin[k] = b;
                end
            end
        end
        return r;
    endfunction

    logic [BCNT_W-1:0] bin_cnt_reg, bin_cnt_next;
    logic [MAG_W-1:0]  prev_reg, prev_next;
    logic [MAG_W-1:0]  cand_reg, cand_next;
    peak_tab_t         tab_reg, tab_next;

    logic              accept;
    logic [BCNT_W-1:0] lim;
    logic              in_range;
    logic              ev1_ok, ev2_ok;
    logic [BIN_W-1:0]  ev1_bin, ev2_bin;
    peak_tab_t         tab_mid, tab_upd;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign lim     = bin_limit(fft_size_log2);

    // Classify the beat: settle the previous candidate, and the current bin on frame end
    always_comb begin
        in_range = bin_cnt_reg < lim;
        ev1_bin  = BIN_W'(bin_cnt_reg - BCNT_W'(1));
        ev2_bin  = BIN_W'(bin_cnt_reg);
        ev1_ok   = (bin_cnt_reg >= BCNT_W'(2)) && (bin_cnt_reg <= lim)
                   && !((bin_cnt_reg >= BCNT_W'(3)) && (cand_reg <= prev_reg))
                   && !(in_range && (cand_reg < s_data.magnitude));
        ev2_ok   = in_range && s_data.frame_end && (bin_cnt_reg >= BCNT_W'(1))
                   && !((bin_cnt_reg >= BCNT_W'(2)) && (s_data.magnitude <= cand_reg));
        tab_mid  = peak_insert(tab_reg, cand_reg, ev1_bin, ev1_ok);
        tab_upd  = peak_insert(tab_mid, s_data.magnitude, ev2_bin, ev2_ok);
    end

    // Hand the finished table to the queue on the frame's last beat
    assign push             = accept && s_data.frame_end;
    assign push_data.tab    = tab_upd;
    assign push_data.lim_ok = lim != '0;

    // Advance bin state; clear everything at frame end
    always_comb begin
        bin_cnt_next = bin_cnt_reg;
        prev_next    = prev_reg;
        cand_next    = cand_reg;
        tab_next     = tab_reg;
        if (accept) begin
            if (s_data.frame_end) begin
                bin_cnt_next = '0;
                prev_next    = '0;
                cand_next    = '0;
                tab_next     = '0;
            end else begin
                if (in_range) begin
                    prev_next = cand_reg;
                    cand_next = s_data.magnitude;
                end
                tab_next = tab_upd;
                if (bin_cnt_reg <= lim) begin
                    bin_cnt_next = bin_cnt_reg + BCNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bin_cnt_reg <= '0;
            prev_reg    <= '0;
            cand_reg    <= '0;
            tab_reg     <= '0;
        end else begin
            bin_cnt_reg <= bin_cnt_next;
            prev_reg    <= prev_next;
            cand_reg    <= cand_next;
            tab_reg     <= tab_next;
        end
    end

endmodule

// ===== rtl/core/sdpf_queue.sv =====
// Short FIFO of frame summaries between the front end and the back end.
// Depends on sdpf_pkg for frame_sum_t and QDEPTH.
`timescale 1ns / 1ps

module sdpf_queue import sdpf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       push,
    input  frame_sum_t push_data,
    output logic       full,
    input  logic       pop,
    output frame_sum_t pop_data,
    output logic       empty
);

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    frame_sum_t       mem_reg [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   cnt_reg;

    assign full     = cnt_reg == (PTR_W + 1)'(QDEPTH);
    assign empty    = cnt_reg == '0;
    assign pop_data = mem_reg[rd_ptr_reg];

    // Store entry on push
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + (PTR_W + 1)'(1);
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - (PTR_W + 1)'(1);
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full) else $error("frame summary pushed into a full queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> !empty) else $error("frame summary popped from an empty queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= (PTR_W + 1)'(QDEPTH)) else $error("queue occupancy above depth");

endmodule

// ===== rtl/core/sdpf_back.sv =====
// Back end: qualifies peaks against the strongest, orders them by bin,
// converts bins to Hz and emits result beats. Depends on sdpf_pkg.
`timescale 1ns / 1ps

module sdpf_back import sdpf_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  cfg_t       cfg,
    input  logic       q_empty,
    input  frame_sum_t q_data,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output out_item_t  m_data
);

    localparam int THR_W  = MAG_W + RATIO_W;
    localparam int PROD_W = RATE_W + BIN_W;
    localparam int KEY_W  = BIN_W + 1;

    // Stage 1: frame summary and threshold product
    logic                           s1_v_reg;
    frame_sum_t                     s1_reg;
    logic [THR_W-1:0]               s1_thr_reg;

    // Stage 2: qualified peaks in bin order, one beat issued per cycle unless stage 3 stalls
    logic                           job_v_reg;
    logic [NUM_PEAKS-1:0][BIN_W-1:0] job_bin_reg;
    logic [NUM_PEAKS-1:0][MAG_W-1:0] job_amp_reg;
    logic [TOTAL_W-1:0]             job_cnt_reg;
    logic [IDX_W-1:0]               job_idx_reg;

    // Stage 3: result fields and frequency product
    logic                           s3_v_reg;
    logic [BIN_W-1:0]               s3_bin_reg;
    logic [MAG_W-1:0]               s3_amp_reg;
    logic [TOTAL_W-1:0]             s3_total_reg;
    logic                           s3_final_reg;
    logic [PROD_W-1:0]              s3_prod_reg;

    // Output register
    logic                           out_v_reg;
    out_item_t                      out_reg;

    logic out_ready, s3_ready, job_ready, s1_ready;
    logic emit, emit_final, s1_move;
    logic [BIN_W-1:0] emit_bin;
    logic [MAG_W-1:0] emit_amp;

    logic [NUM_PEAKS-1:0]            qual;
    logic [TOTAL_W-1:0]              qual_cnt;
    logic [NUM_PEAKS-1:0][KEY_W-1:0] srt_key;
    logic [NUM_PEAKS-1:0][MAG_W-1:0] srt_amp;
    logic [KEY_W-1:0]                tmp_key;
    logic [MAG_W-1:0]                tmp_amp;

    // Handshake chain, output side first
    assign out_ready  = !out_v_reg || m_ready;
    assign s3_ready   = !s3_v_reg || out_ready;
    assign emit       = job_v_reg && s3_ready;
    assign emit_final = (job_cnt_reg == '0)
                        || (TOTAL_W'(job_idx_reg) == job_cnt_reg - TOTAL_W'(1));
    assign job_ready  = !job_v_reg || (emit && emit_final);
    assign s1_move    = s1_v_reg && job_ready;
    assign s1_ready   = !s1_v_reg || job_ready;
    assign q_pop      = !q_empty && s1_ready;

    // Qualify leading peaks, then sort them by bin with unqualified ones last
    always_comb begin
        qual_cnt = '0;
        tmp_key  = '0;
        tmp_amp  = '0;
        for (int k = 0; k < NUM_PEAKS; k++) begin
            qual[k] = s1_reg.lim_ok && (s1_reg.tab.amp[k] != '0)
                      && (THR_W'({s1_reg.tab.amp[k], {Q_SHIFT{1'b0}}}) >= s1_thr_reg);
            if (k > 0) begin
                qual[k] = qual[k] && qual[k-1];
            end
            if (qual[k]) begin
                qual_cnt = qual_cnt + TOTAL_W'(1);
            end
            srt_key[k] = {!qual[k], s1_reg.tab.bin[k]};
            srt_amp[k] = s1_reg.tab.amp[k];
        end
        for (int p = 0; p < NUM_PEAKS; p++) begin
            for (int k = p % 2; k + 1 < NUM_PEAKS; k += 2) begin
                if (srt_key[k] > srt_key[k+1]) begin
                    tmp_key      = srt_key[k];
                    tmp_amp      = srt_amp[k];
                    srt_key[k]   = srt_key[k+1];
                    srt_amp[k]   = srt_amp[k+1];
                    srt_key[k+1] = tmp_key;
                    srt_amp[k+1] = tmp_amp;
                end
            end
        end
    end

    // Pick the peak for this beat; an empty frame gives one all-zero beat
    always_comb begin
        emit_bin = '0;
        emit_amp = '0;
        if (job_cnt_reg != '0) begin
            emit_bin = job_bin_reg[job_idx_reg];
            emit_amp = job_amp_reg[job_idx_reg];
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (q_pop) begin
            s1_reg     <= q_data;
            s1_thr_reg <= THR_W'(q_data.tab.amp[0]) * THR_W'(cfg.min_ratio_q8);
        end
        if (s1_move) begin
            job_cnt_reg <= qual_cnt;
            for (int k = 0; k < NUM_PEAKS; k++) begin
                job_bin_reg[k] <= srt_key[k][BIN_W-1:0];
                job_amp_reg[k] <= srt_amp[k];
            end
        end
        if (emit) begin
            s3_bin_reg   <= emit_bin;
            s3_amp_reg   <= emit_amp;
            s3_total_reg <= job_cnt_reg;
            s3_final_reg <= emit_final;
            s3_prod_reg  <= PROD_W'(cfg.sample_rate_hz) * PROD_W'(emit_bin);
        end
        if (out_ready && s3_v_reg) begin
            out_reg.peak_bin     <= s3_bin_reg;
            out_reg.peak_freq_hz <= FREQ_W'(s3_prod_reg >> cfg.fft_size_log2);
            out_reg.peak_amp     <= s3_amp_reg;
            out_reg.peak_total   <= s3_total_reg;
            out_reg.final_res    <= s3_final_reg;
        end
    end

    // Stage valids and beat index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_v_reg    <= 1'b0;
            job_v_reg   <= 1'b0;
            job_idx_reg <= '0;
            s3_v_reg    <= 1'b0;
            out_v_reg   <= 1'b0;
        end else begin
            if (q_pop) begin
                s1_v_reg <= 1'b1;
            end else if (s1_move) begin
                s1_v_reg <= 1'b0;
            end
            if (s1_move) begin
                job_v_reg   <= 1'b1;
                job_idx_reg <= '0;
            end else if (emit && emit_final) begin
                job_v_reg <= 1'b0;
            end else if (emit) begin
                job_idx_reg <= job_idx_reg + IDX_W'(1);
            end
            if (s3_ready) begin
                s3_v_reg <= emit;
            end
            if (out_ready) begin
                out_v_reg <= s3_v_reg;
            end
        end
    end

    assign m_valid = out_v_reg;
    assign m_data  = out_reg;

    a_empty_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.peak_total == '0) |-> (m_data.final_res && m_data.peak_amp == '0))
        else $error("empty-frame beat not marked final or carries an amplitude");

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (job_v_reg && job_cnt_reg != '0) |-> (TOTAL_W'(job_idx_reg) < job_cnt_reg))
        else $error("beat index past the qualified peak count");

    a_bin_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (job_v_reg && job_cnt_reg >= TOTAL_W'(2)) |-> (job_bin_reg[0] < job_bin_reg[1]))
        else $error("qualified peaks not in ascending bin order");

endmodule
